// File: hw/rtl/olt_pkg.sv
// ----------------------------------------------------------------------------
// olt_pkg: shared types for the ordered list table
// Command and status codes, and the operation that the controller issues to
// every cell of the chain.
// ----------------------------------------------------------------------------
package olt_pkg;

    localparam int unsigned CMD_W   = 2;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned STAT_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD    = 2'd0,
        CELL_INSERT  = 2'd1,
        CELL_MARK    = 2'd2,
        CELL_COMPACT = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [POS_W-1:0]  position;
    } t_cell_ctl;

endpackage

// File: hw/rtl/olt_cell.sv
// ----------------------------------------------------------------------------
// olt_cell: one entry of the ordered list table
// Holds one word and its valid bit. Takes the word of its left neighbor on an
// insert, drops its word when it matches on a remove, and moves its word one
// place toward the front while a gap stands before it.
// ----------------------------------------------------------------------------
module olt_cell #(
    parameter int unsigned INDEX      = 0,
    parameter int unsigned ELEM_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  olt_pkg::t_cell_ctl    i_ctl,
    input  logic [ELEM_WIDTH-1:0] i_key,
    input  logic [ELEM_WIDTH-1:0] i_left_data,
    input  logic                  i_left_valid,
    input  logic [ELEM_WIDTH-1:0] i_right_data,
    input  logic                  i_right_valid,
    output logic [ELEM_WIDTH-1:0] o_data,
    output logic                  o_valid,
    output logic                  o_hit,
    output logic                  o_sel,
    output logic                  o_gap
);

    logic [ELEM_WIDTH-1:0] r_data;
    logic                  r_valid;
    logic                  match;

    assign match   = (r_data == i_key);
    assign o_data  = r_data;
    assign o_valid = r_valid;
    assign o_hit   = r_valid && match;
    assign o_sel   = r_valid && (INDEX < (1 << olt_pkg::POS_W))
                     && (i_ctl.position == olt_pkg::POS_W'(INDEX));
    assign o_gap   = !r_valid && i_right_valid;

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            olt_pkg::CELL_INSERT: begin
                r_data <= i_left_data;
            end
            olt_pkg::CELL_COMPACT: begin
                if (!r_valid && i_right_valid) begin
                    r_data <= i_right_data;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            case (i_ctl.op)
                olt_pkg::CELL_INSERT: begin
                    r_valid <= i_left_valid;
                end
                olt_pkg::CELL_MARK: begin
                    r_valid <= r_valid && !match;
                end
                olt_pkg::CELL_COMPACT: begin
                    if (!r_valid && i_right_valid) begin
                        r_valid <= 1'b1;
                    end else if (r_valid && !i_left_valid) begin
                        r_valid <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/ordered_list_table_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_table_unit: bounded ordered list of words
// A chain of DEPTH cells, newest entry in cell 0, run by a small sequencer
// that executes insert, remove, search and read commands.
//
//   channel  direction  valid         stall         payload
//   input    in         i_in_valid    o_in_stall    i_command i_value i_position
//   output   out        o_out_valid   i_out_stall   o_found o_data_out
//                                                   o_entry_count o_status
//
// Insert, search and read pass through the execute and response states before
// their result beat enters the output register, and no new command is taken
// until then. Remove adds a compaction state in which the chain closes its
// gaps, each held word moving one place per cycle.
// Reset empties the list at once; there is no clearing pass.
// A result beat waits in the output register while i_out_stall is high; the
// next command still runs, but its result waits until that register is free.
// ----------------------------------------------------------------------------
module ordered_list_table_unit #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned ELEM_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [olt_pkg::CMD_W-1:0]     i_command,
    input  logic [olt_pkg::WORD_W-1:0]    i_value,
    input  logic [olt_pkg::POS_W-1:0]     i_position,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_found,
    output logic [olt_pkg::WORD_W-1:0]    o_data_out,
    output logic [olt_pkg::COUNT_W-1:0]   o_entry_count,
    output logic [olt_pkg::STAT_W-1:0]    o_status
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_COMPACT,
        S_RESP
    } t_state;

    t_state                       r_state;
    olt_pkg::t_cmd                r_cmd;
    logic [ELEM_WIDTH-1:0]        r_value;
    logic [olt_pkg::POS_W-1:0]    r_position;
    logic                         r_found;
    logic [olt_pkg::WORD_W-1:0]   r_data;
    olt_pkg::t_status             r_status;
    logic                         r_out_valid;
    logic                         r_out_found;
    logic [olt_pkg::WORD_W-1:0]   r_out_data;
    logic [olt_pkg::COUNT_W-1:0]  r_out_count;
    olt_pkg::t_status             r_out_status;

    olt_pkg::t_cell_ctl           cell_ctl;
    logic [ELEM_WIDTH-1:0]        cell_data [DEPTH];
    logic [ELEM_WIDTH-1:0]        left_data [DEPTH];
    logic [ELEM_WIDTH-1:0]        right_data [DEPTH];
    logic [DEPTH-1:0]             left_valid;
    logic [DEPTH-1:0]             right_valid;
    logic [DEPTH-1:0]             valid_vec;
    logic [DEPTH-1:0]             hit_vec;
    logic [DEPTH-1:0]             sel_vec;
    logic [DEPTH-1:0]             gap_vec;
    logic [ELEM_WIDTH-1:0]        rd_data;
    logic [CNT_W-1:0]             count;
    logic [DEPTH:0]               valid_ext;
    logic                         full;
    logic                         in_accept;
    logic                         out_free;

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign full      = valid_vec[DEPTH-1];
    assign valid_ext = {1'b0, valid_vec};

    always_comb begin
        cell_ctl.position = r_position;
        cell_ctl.op       = olt_pkg::CELL_HOLD;
        if (r_state == S_EXEC) begin
            if (r_cmd == olt_pkg::CMD_INSERT && !full) begin
                cell_ctl.op = olt_pkg::CELL_INSERT;
            end else if (r_cmd == olt_pkg::CMD_REMOVE) begin
                cell_ctl.op = olt_pkg::CELL_MARK;
            end
        end else if (r_state == S_COMPACT && (|gap_vec)) begin
            cell_ctl.op = olt_pkg::CELL_COMPACT;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign left_data[g]  = r_value;
            assign left_valid[g] = 1'b1;
        end else begin : g_body
            assign left_data[g]  = cell_data[g-1];
            assign left_valid[g] = valid_vec[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign right_data[g]  = '0;
            assign right_valid[g] = 1'b0;
        end else begin : g_inner
            assign right_data[g]  = cell_data[g+1];
            assign right_valid[g] = valid_vec[g+1];
        end

        olt_cell #(
            .INDEX      (g),
            .ELEM_WIDTH (ELEM_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (cell_ctl),
            .i_key         (r_value),
            .i_left_data   (left_data[g]),
            .i_left_valid  (left_valid[g]),
            .i_right_data  (right_data[g]),
            .i_right_valid (right_valid[g]),
            .o_data        (cell_data[g]),
            .o_valid       (valid_vec[g]),
            .o_hit         (hit_vec[g]),
            .o_sel         (sel_vec[g]),
            .o_gap         (gap_vec[g])
        );
    end

    always_comb begin
        rd_data = '0;
        count   = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (sel_vec[i]) begin
                rd_data = rd_data | cell_data[i];
            end
            if (valid_vec[i] && !valid_ext[i+1]) begin
                count = count | CNT_W'(i + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd      <= olt_pkg::t_cmd'(i_command);
            r_value    <= ELEM_WIDTH'(i_value);
            r_position <= i_position;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_found      <= 1'b0;
            r_data       <= '0;
            r_status     <= olt_pkg::ST_OK;
            r_out_found  <= 1'b0;
            r_out_data   <= '0;
            r_out_count  <= '0;
            r_out_status <= olt_pkg::ST_OK;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    unique case (r_cmd)
                        olt_pkg::CMD_INSERT: begin
                            r_found  <= 1'b0;
                            r_data   <= '0;
                            r_status <= full ? olt_pkg::ST_FULL : olt_pkg::ST_OK;
                            r_state  <= S_RESP;
                        end
                        olt_pkg::CMD_REMOVE: begin
                            r_found  <= |hit_vec;
                            r_data   <= '0;
                            r_status <= olt_pkg::ST_OK;
                            r_state  <= S_COMPACT;
                        end
                        olt_pkg::CMD_SEARCH: begin
                            r_found  <= |hit_vec;
                            r_data   <= (|hit_vec) ? olt_pkg::WORD_W'(r_value) : '0;
                            r_status <= olt_pkg::ST_OK;
                            r_state  <= S_RESP;
                        end
                        olt_pkg::CMD_READ: begin
                            r_found  <= |sel_vec;
                            r_data   <= olt_pkg::WORD_W'(rd_data);
                            r_status <= (|sel_vec) ? olt_pkg::ST_OK : olt_pkg::ST_RANGE;
                            r_state  <= S_RESP;
                        end
                        default: begin
                            r_state <= S_RESP;
                        end
                    endcase
                end
                S_COMPACT: begin
                    if (!(|gap_vec)) begin
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_found  <= r_found;
                        r_out_data   <= r_data;
                        r_out_count  <= olt_pkg::COUNT_W'(count);
                        r_out_status <= r_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_found       = r_out_found;
    assign o_data_out    = r_out_data;
    assign o_entry_count = r_out_count;
    assign o_status      = r_out_status;

`ifndef ASSERT_OFF
    a_packed_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (((valid_vec >> 1) & ~valid_vec) == '0))
        else $error("List entries are not packed toward the front while idle.");

    a_compact_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMPACT) |=> ($countones(valid_vec) == $past($countones(valid_vec))))
        else $error("Compaction changed the number of held entries.");

    a_found_means_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_found && (o_status != olt_pkg::ST_OK)))
        else $error("A result beat reports a hit together with an error status.");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == olt_pkg::ST_FULL))
            |-> (o_entry_count == olt_pkg::COUNT_W'(DEPTH)))
        else $error("A dropped insert reports a count below a full list.");
`endif

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for ordered_list_table_unit
// Drives insert, remove, search and read commands through the valid/stall
// input channel and checks every output beat against a list predictor held
// in a small scoreboard class. Directed commands cover the empty list, a
// full list, duplicates and range errors. Random phases then fill and drain
// the list while both channels idle at random in all phases but one.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned LIST_DEPTH = 16;

    typedef struct packed {
        logic                         found;
        logic [olt_pkg::WORD_W-1:0]   data;
        logic [olt_pkg::COUNT_W-1:0]  count;
        logic [olt_pkg::STAT_W-1:0]   status;
    } t_list_result;

    class list_table_scoreboard;
        logic [olt_pkg::WORD_W-1:0] words [LIST_DEPTH];
        int unsigned       held;
        t_list_result      pending_results [$];
        int unsigned       errors;
        int unsigned       n_checked;
        int unsigned       n_full;
        int unsigned       n_range;
        int unsigned       n_search_hits;
        int unsigned       n_remove_hits;

        function new();
            held          = 0;
            errors        = 0;
            n_checked     = 0;
            n_full        = 0;
            n_range       = 0;
            n_search_hits = 0;
            n_remove_hits = 0;
        endfunction

        function int unsigned pending_count();
            return pending_results.size();
        endfunction

        // Applies one accepted command to the list and queues its result.
        function void log_command(olt_pkg::t_cmd cmd, logic [olt_pkg::WORD_W-1:0] value,
                                  logic [olt_pkg::POS_W-1:0] pos);
            t_list_result r;
            int unsigned  i;
            int unsigned  w;
            r.found  = 1'b0;
            r.data   = '0;
            r.status = olt_pkg::ST_OK;
            case (cmd)
                olt_pkg::CMD_INSERT: begin
                    if (held >= LIST_DEPTH) begin
                        r.status = olt_pkg::ST_FULL;
                        n_full++;
                    end else begin
                        for (i = held; i > 0; i--)
                            words[i] = words[i-1];
                        words[0] = value;
                        held++;
                    end
                end
                olt_pkg::CMD_REMOVE: begin
                    w = 0;
                    for (i = 0; i < held; i++) begin
                        if (words[i] == value) begin
                            r.found = 1'b1;
                        end else begin
                            words[w] = words[i];
                            w++;
                        end
                    end
                    held = w;
                    if (r.found)
                        n_remove_hits++;
                end
                olt_pkg::CMD_SEARCH: begin
                    for (i = 0; i < held; i++) begin
                        if (!r.found && words[i] == value) begin
                            r.found = 1'b1;
                            r.data  = words[i];
                        end
                    end
                    if (r.found)
                        n_search_hits++;
                end
                default: begin
                    if (pos < held) begin
                        r.found = 1'b1;
                        r.data  = words[pos];
                    end else begin
                        r.status = olt_pkg::ST_RANGE;
                        n_range++;
                    end
                end
            endcase
            r.count = olt_pkg::COUNT_W'(held);
            pending_results.push_back(r);
        endfunction

        function void check_result(logic found, logic [olt_pkg::WORD_W-1:0] data,
                                   logic [olt_pkg::COUNT_W-1:0] count,
                                   logic [olt_pkg::STAT_W-1:0] status);
            t_list_result e;
            if (pending_results.size() == 0) begin
                $error("result beat with no command outstanding");
                errors++;
                return;
            end
            e = pending_results.pop_front();
            n_checked++;
            if (found !== e.found) begin
                $error("found: expected %0d, actual %0d", e.found, found);
                errors++;
            end
            if (data !== e.data) begin
                $error("data_out: expected %h, actual %h", e.data, data);
                errors++;
            end
            if (count !== e.count) begin
                $error("entry_count: expected %0d, actual %0d", e.count, count);
                errors++;
            end
            if (status !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, status);
                errors++;
            end
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic [olt_pkg::CMD_W-1:0]    i_command;
    logic [olt_pkg::WORD_W-1:0]   i_value;
    logic [olt_pkg::POS_W-1:0]    i_position;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic                         o_found;
    logic [olt_pkg::WORD_W-1:0]   o_data_out;
    logic [olt_pkg::COUNT_W-1:0]  o_entry_count;
    logic [olt_pkg::STAT_W-1:0]   o_status;

    bit                    steady;
    list_table_scoreboard  sb;

    ordered_list_table_unit #(
        .DEPTH      (LIST_DEPTH),
        .ELEM_WIDTH (olt_pkg::WORD_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_value       (i_value),
        .i_position    (i_position),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_found       (o_found),
        .o_data_out    (o_data_out),
        .o_entry_count (o_entry_count),
        .o_status      (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    task automatic send_command(input olt_pkg::t_cmd cmd,
                                input logic [olt_pkg::WORD_W-1:0] value,
                                input logic [olt_pkg::POS_W-1:0] pos);
        while (!steady && $urandom_range(99) < 10) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_value    <= value;
        i_position <= pos;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.log_command(cmd, value, pos);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending_count() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_directed();
        int unsigned                k;
        logic [olt_pkg::WORD_W-1:0] v;
        send_command(olt_pkg::CMD_READ, '0, 4'd0);
        send_command(olt_pkg::CMD_SEARCH, '0, 4'd15);
        send_command(olt_pkg::CMD_REMOVE, '1, 4'd0);
        for (k = 0; k < LIST_DEPTH; k++) begin
            case (k)
                0:       v = '0;
                1, 2:    v = '1;
                default: v = 32'h1357_9BDF ^ (k * 32'h0101_0101);
            endcase
            send_command(olt_pkg::CMD_INSERT, v, olt_pkg::POS_W'(k));
        end
        send_command(olt_pkg::CMD_INSERT, 32'hDEAD_BEEF, 4'd15);
        send_command(olt_pkg::CMD_READ, '1, 4'd15);
        send_command(olt_pkg::CMD_READ, '0, 4'd0);
        send_command(olt_pkg::CMD_SEARCH, '1, 4'd0);
        send_command(olt_pkg::CMD_SEARCH, 32'h8000_0001, 4'd0);
        send_command(olt_pkg::CMD_REMOVE, '1, 4'd0);
        send_command(olt_pkg::CMD_READ, '0, 4'd15);
        drain_results();
    endtask

    // Insert-heavy, remove-heavy and mixed phases over a small pool of
    // words, so that duplicates, a full list and an empty list all recur.
    task automatic run_random(input int unsigned n_phases, input int unsigned per_phase);
        int unsigned                phase;
        int unsigned                k;
        int unsigned                j;
        int unsigned                roll;
        logic [olt_pkg::WORD_W-1:0] pool [6];
        olt_pkg::t_cmd              cmd;
        logic [olt_pkg::WORD_W-1:0] v;
        logic [olt_pkg::POS_W-1:0]  p;
        for (phase = 0; phase < n_phases; phase++) begin
            steady = (phase == 4);
            for (j = 0; j < 6; j++)
                pool[j] = $urandom;
            if (phase % 2 == 0)
                pool[0] = '0;
            else
                pool[1] = '1;
            for (k = 0; k < per_phase; k++) begin
                roll = $urandom_range(99);
                case (phase % 3)
                    0:       cmd = (roll < 60) ? olt_pkg::CMD_INSERT :
                                   (roll < 70) ? olt_pkg::CMD_REMOVE :
                                   (roll < 85) ? olt_pkg::CMD_SEARCH : olt_pkg::CMD_READ;
                    1:       cmd = (roll < 25) ? olt_pkg::CMD_INSERT :
                                   (roll < 60) ? olt_pkg::CMD_REMOVE :
                                   (roll < 80) ? olt_pkg::CMD_SEARCH : olt_pkg::CMD_READ;
                    default: cmd = olt_pkg::t_cmd'(roll % 4);
                endcase
                v = ($urandom_range(99) < 85) ? pool[$urandom_range(5)] : $urandom;
                if ($urandom_range(99) < 65 && sb.held > 0)
                    p = olt_pkg::POS_W'($urandom_range(sb.held - 1));
                else
                    p = olt_pkg::POS_W'($urandom);
                send_command(cmd, v, p);
            end
            drain_results();
        end
        steady = 1'b0;
    endtask

    initial begin
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_found, o_data_out, o_entry_count, o_status);
            i_out_stall <= !steady && ($urandom_range(99) < 10);
        end
    end

    initial begin
        sb = new();
        steady = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_command  <= olt_pkg::CMD_INSERT;
        i_value    <= '0;
        i_position <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random(10, 100);
        drain_results();
        repeat (40) @(posedge i_clk);
        $display("tb_top: %0d result beats checked, %0d inserts dropped on a full list,",
                 sb.n_checked, sb.n_full);
        $display("tb_top: %0d reads out of range, %0d search hits, %0d removes that matched",
                 sb.n_range, sb.n_search_hits, sb.n_remove_hits);
        if (sb.errors == 0 && sb.pending_count() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// File: ordered_list_table_unit.f
hw/rtl/olt_pkg.sv
hw/rtl/olt_cell.sv
hw/rtl/ordered_list_table_unit.sv
verif/tb_top.sv
